[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the partition table checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset
`define AST_SAME(label, ant, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on aclk, off while in reset
`define AST_NEXT(label, ant, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/plst_pkg.sv]
// ----------------------------------------------------------------------------
// plst_pkg
// Types and codes shared by the partition table front, queue and back end.
// ----------------------------------------------------------------------------
package plst_pkg;

    // Request codes as they arrive on the input channel
    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_ASSIGN = 3'd1;
    localparam logic [2:0] REQ_SWAP   = 3'd2;
    localparam logic [2:0] REQ_COST   = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ITEM_COUNT = 2'd0;
    localparam logic [1:0] CFG_PART_COUNT = 2'd1;
    localparam logic [1:0] CFG_TARGET_SUM = 2'd2;

    localparam int FIFO_DEPTH = 2;

    // Classified request kinds
    typedef enum logic [2:0] {
        K_CLEAR,
        K_ASSIGN,
        K_SWAP,
        K_COST,
        K_READ,
        K_REJECT
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RANGE,
        ST_INCOMPLETE
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CLR,
        S_RDA,
        S_RDB,
        S_SWW,
        S_SWC,
        S_CDEV,
        S_CSQ,
        S_CACC,
        S_DONE
    } bstate_t;

    typedef struct packed {
        kind_t       kind;
        logic [10:0] item_a;
        logic [10:0] item_b;
        logic [4:0]  part_sel;
    } cmd_t;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef struct packed {
        logic [19:0] part_total;
        logic [10:0] part_members;
        logic [42:0] cost_value;
        logic        cost_valid;
        logic        all_assigned;
        status_t     status;
    } res_t;

endpackage

[rtl/partition_local_search_table.sv]
// Partition table: tracks which part owns each number 1..n plus a member count
// and sum per part (slot 0 is the unassigned pool), and serves clear, assign,
// swap, cost and read requests one at a time. After reset the owner memory is
// swept before the first item is taken. A read, a rejected request or an
// incomplete swap or cost goes straight to the output register; an assign
// takes one registered read of the owner memory, then the write; a swap reads
// both numbers from the owner memory one after the other and, unless both
// share a part, writes both owners and does the multiply for the cost
// update; a cost request runs one squarer step chain per part and a clear
// runs a write sweep of the owner memory. A two-entry queue lets the front
// take new items while the back end works, and the output register holds a
// result until it is taken.
// Write configuration only while no request is in flight, then issue a clear.
// ----------------------------------------------------------------------------
// partition_local_search_table
// Top level: configuration registers, request front, queue and back end.
// ----------------------------------------------------------------------------
module partition_local_search_table #(
    parameter int MAX_ITEMS = 1024,
    parameter int MAX_PARTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // item_a[10:0], item_b[21:11], part_sel[26:22], zero fill
    input  logic [2:0]  s_tuser,     // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,     // status[1:0], all_assigned[2], cost_valid[3],
                                     // cost_value[46:4], part_members[57:47],
                                     // part_total[77:58], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic [10:0]        item_count_reg;
    logic [4:0]         part_count_reg;
    logic [19:0]        target_sum_reg;
    logic [10:0]        eff_n;
    logic [4:0]         eff_k;
    logic               init_busy;
    logic               q_full;
    logic               q_push;
    logic               q_pop;
    plst_pkg::cmd_t     q_cmd;
    plst_pkg::q_head_t  q_head;
    plst_pkg::res_t     res;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= 11'd1024;
            part_count_reg <= 5'd1;
            target_sum_reg <= 20'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                plst_pkg::CFG_ITEM_COUNT: item_count_reg <= cfg_data[10:0];
                plst_pkg::CFG_PART_COUNT: part_count_reg <= cfg_data[4:0];
                plst_pkg::CFG_TARGET_SUM: target_sum_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Limit the counts to the built table sizes
    assign eff_n = (int'(item_count_reg) > MAX_ITEMS) ? 11'(MAX_ITEMS) : item_count_reg;
    assign eff_k = (int'(part_count_reg) > MAX_PARTS) ? 5'(MAX_PARTS) : part_count_reg;

    plst_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .eff_n     (eff_n),
        .eff_k     (eff_k),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    plst_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    plst_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .MAX_PARTS (MAX_PARTS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .pop        (q_pop),
        .eff_n      (eff_n),
        .eff_k      (eff_k),
        .target_sum (target_sum_reg),
        .init_busy  (init_busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    assign m_tdata = {2'b00, res.part_total, res.part_members, res.cost_value,
                      res.cost_valid, res.all_assigned, res.status};

endmodule

[rtl/plst_front.sv]
// ----------------------------------------------------------------------------
// plst_front
// Accepts request items and classifies them, range checks included.
// ----------------------------------------------------------------------------
module plst_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,    // item_a, item_b, part_sel, zero fill
    input  logic [2:0]         s_tuser,    // req_type
    input  logic [10:0]        eff_n,
    input  logic [4:0]         eff_k,
    input  logic               init_busy,
    input  logic               q_full,
    output logic               q_push,
    output plst_pkg::cmd_t     q_cmd
);

    logic [10:0] item_a;
    logic [10:0] item_b;
    logic [4:0]  part_sel;
    logic        a_ok;
    logic        b_ok;
    logic        sel_ok;

    assign item_a   = s_tdata[10:0];
    assign item_b   = s_tdata[21:11];
    assign part_sel = s_tdata[26:22];

    // Hold off while the queue is full or the table is being swept after reset
    assign s_tready = !q_full && !init_busy;
    assign q_push   = s_tvalid && s_tready;

    assign a_ok   = (item_a != 11'd0) && (item_a <= eff_n);
    assign b_ok   = (item_b != 11'd0) && (item_b <= eff_n);
    assign sel_ok = (part_sel <= eff_k);

    // Classify the request
    always_comb begin
        q_cmd.item_a   = item_a;
        q_cmd.item_b   = item_b;
        q_cmd.part_sel = part_sel;
        case (s_tuser)
            plst_pkg::REQ_CLEAR: begin
                q_cmd.kind = plst_pkg::K_CLEAR;
            end
            plst_pkg::REQ_ASSIGN: begin
                q_cmd.kind = (a_ok && sel_ok) ? plst_pkg::K_ASSIGN : plst_pkg::K_REJECT;
            end
            plst_pkg::REQ_SWAP: begin
                q_cmd.kind = (a_ok && b_ok) ? plst_pkg::K_SWAP : plst_pkg::K_REJECT;
            end
            plst_pkg::REQ_COST: begin
                q_cmd.kind = plst_pkg::K_COST;
            end
            plst_pkg::REQ_READ: begin
                q_cmd.kind = sel_ok ? plst_pkg::K_READ : plst_pkg::K_REJECT;
            end
            default: begin
                q_cmd.kind = plst_pkg::K_REJECT;
            end
        endcase
    end

endmodule

[rtl/plst_fifo.sv]
// ----------------------------------------------------------------------------
// plst_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module plst_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  plst_pkg::cmd_t     push_cmd,
    output logic               full,
    input  logic               pop,
    output plst_pkg::q_head_t  head
);

    localparam int PW = (plst_pkg::FIFO_DEPTH > 1) ? $clog2(plst_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(plst_pkg::FIFO_DEPTH + 1);

    plst_pkg::cmd_t  buf_reg [0:plst_pkg::FIFO_DEPTH-1];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full       = (count_reg == CW'(plst_pkg::FIFO_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = buf_reg[rd_ptr_reg];

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(plst_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(plst_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[rtl/plst_back.sv]
// ----------------------------------------------------------------------------
// plst_back
// Executes classified requests on the owner memory and the per-slot tables.
// ----------------------------------------------------------------------------
module plst_back #(
    parameter int MAX_ITEMS = 1024,
    parameter int MAX_PARTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  plst_pkg::q_head_t  head,
    output logic               pop,
    input  logic [10:0]        eff_n,
    input  logic [4:0]         eff_k,
    input  logic [19:0]        target_sum,
    output logic               init_busy,
    output logic               out_valid,
    input  logic               out_ready,
    output plst_pkg::res_t     out_res
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int SW = $clog2(MAX_PARTS + 1);
    localparam int JW = $clog2(MAX_PARTS + 2);

    // Owner memory
    logic [SW-1:0]   owner_mem [0:MAX_ITEMS-1];
    logic [SW-1:0]   mem_q_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [SW-1:0]   mem_wd;
    logic [AW-1:0]   mem_ra;

    plst_pkg::bstate_t state_reg, state_next;
    plst_pkg::cmd_t    cur_reg, cur_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [31:0]       sizes_reg [0:MAX_PARTS];
    logic [31:0]       sizes_next [0:MAX_PARTS];
    logic [31:0]       sums_reg [0:MAX_PARTS];
    logic [31:0]       sums_next [0:MAX_PARTS];
    logic [42:0]       cost_reg, cost_next;
    logic              cost_ok_reg, cost_ok_next;
    logic [SW-1:0]     s1_reg, s1_next;
    logic [SW-1:0]     s2_reg, s2_next;
    logic [31:0]       sum1_reg, sum1_next;
    logic [42:0]       g_reg, g_next;
    logic [42:0]       prod_reg, prod_next;
    logic [31:0]       dev_reg, dev_next;
    logic [42:0]       sq_reg, sq_next;
    logic [JW-1:0]     j_reg, j_next;
    plst_pkg::status_t res_status_reg, res_status_next;
    logic [10:0]       res_members_reg, res_members_next;
    logic [19:0]       res_total_reg, res_total_next;
    logic              out_valid_reg, out_valid_next;
    plst_pkg::res_t    out_reg, out_next;

    int                rd_idx;
    logic [31:0]       sizes_rd;
    logic [31:0]       sums_rd;
    logic [SW-1:0]     q_slot;
    logic              dneg;
    logic [10:0]       dmag;
    logic [42:0]       d43;
    logic [31:0]       d32;
    logic [21:0]       full_sum;
    logic [63:0]       sq64;
    logic [53:0]       swp_prod;
    logic [42:0]       swp_delta;

    function automatic logic [AW-1:0] item_addr(input logic [10:0] v);
        logic [10:0] t;
        t = v - 11'd1;
        return AW'(t);
    endfunction

    assign init_busy = (state_reg == plst_pkg::S_INIT);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // Memory write port and registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            owner_mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= owner_mem[mem_ra];
    end

    // Slot read mux, one address per cycle
    always_comb begin
        sizes_rd = '0;
        sums_rd  = '0;
        for (int i = 0; i <= MAX_PARTS; i++) begin
            if (i == rd_idx) begin
                sizes_rd = sizes_reg[i];
                sums_rd  = sums_reg[i];
            end
        end
    end

    // Owner codes beyond the slot range count as the pool
    assign q_slot = (int'(mem_q_reg) > MAX_PARTS) ? '0 : mem_q_reg;

    // Swap distance b - a, as magnitude and in two's complement
    assign dneg = (cur_reg.item_b < cur_reg.item_a);
    assign dmag = dneg ? (cur_reg.item_a - cur_reg.item_b) : (cur_reg.item_b - cur_reg.item_a);
    assign d43  = dneg ? (43'd0 - 43'(dmag)) : 43'(dmag);
    assign d32  = dneg ? (32'd0 - 32'(dmag)) : 32'(dmag);

    assign full_sum  = (22'(eff_n) * (22'(eff_n) + 22'd1)) >> 1;
    assign sq64      = {32'd0, dev_reg} * {32'd0, dev_reg};
    assign swp_prod  = {43'd0, dmag} * {11'd0, g_reg};
    assign swp_delta = dneg ? (43'd0 - prod_reg) : prod_reg;

    // Sequencer: next state and datapath
    always_comb begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        sweep_next       = sweep_reg;
        sizes_next       = sizes_reg;
        sums_next        = sums_reg;
        cost_next        = cost_reg;
        cost_ok_next     = cost_ok_reg;
        s1_next          = s1_reg;
        s2_next          = s2_reg;
        sum1_next        = sum1_reg;
        g_next           = g_reg;
        prod_next        = prod_reg;
        dev_next         = dev_reg;
        sq_next          = sq_reg;
        j_next           = j_reg;
        res_status_next  = res_status_reg;
        res_members_next = res_members_reg;
        res_total_next   = res_total_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        pop              = 1'b0;
        mem_we           = 1'b0;
        mem_wa           = sweep_reg;
        mem_wd           = '0;
        mem_ra           = item_addr(cur_reg.item_a);
        rd_idx           = 0;

        // Drop the result once taken
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            plst_pkg::S_INIT: begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(MAX_ITEMS - 1)) begin
                    sweep_next = '0;
                    state_next = plst_pkg::S_IDLE;
                end
            end
            plst_pkg::S_IDLE: begin
                rd_idx = int'(head.cmd.part_sel);
                mem_ra = item_addr(head.cmd.item_a);
                if (head.valid) begin
                    pop              = 1'b1;
                    cur_next         = head.cmd;
                    res_status_next  = plst_pkg::ST_OK;
                    res_members_next = '0;
                    res_total_next   = '0;
                    case (head.cmd.kind)
                        plst_pkg::K_CLEAR: begin
                            for (int i = 0; i <= MAX_PARTS; i++) begin
                                sizes_next[i] = '0;
                                sums_next[i]  = '0;
                            end
                            sizes_next[0] = 32'(eff_n);
                            sums_next[0]  = 32'(full_sum);
                            cost_ok_next  = 1'b0;
                            sweep_next    = '0;
                            state_next    = plst_pkg::S_CLR;
                        end
                        plst_pkg::K_ASSIGN: begin
                            state_next = plst_pkg::S_RDA;
                        end
                        plst_pkg::K_SWAP: begin
                            if (sizes_reg[0] != 32'd0) begin
                                res_status_next = plst_pkg::ST_INCOMPLETE;
                                state_next      = plst_pkg::S_DONE;
                            end else begin
                                state_next = plst_pkg::S_RDA;
                            end
                        end
                        plst_pkg::K_COST: begin
                            if (sizes_reg[0] != 32'd0) begin
                                res_status_next = plst_pkg::ST_INCOMPLETE;
                                state_next      = plst_pkg::S_DONE;
                            end else begin
                                cost_next  = '0;
                                j_next     = JW'(1);
                                state_next = plst_pkg::S_CDEV;
                            end
                        end
                        plst_pkg::K_READ: begin
                            res_members_next = sizes_rd[10:0];
                            res_total_next   = sums_rd[19:0];
                            state_next       = plst_pkg::S_DONE;
                        end
                        default: begin
                            res_status_next = plst_pkg::ST_RANGE;
                            state_next      = plst_pkg::S_DONE;
                        end
                    endcase
                end
            end
            plst_pkg::S_CLR: begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(MAX_ITEMS - 1)) begin
                    sweep_next = '0;
                    state_next = plst_pkg::S_DONE;
                end
            end
            plst_pkg::S_RDA: begin
                rd_idx = int'(q_slot);
                if (cur_reg.kind == plst_pkg::K_ASSIGN) begin
                    // Move the number from its old slot to the selected one
                    for (int i = 0; i <= MAX_PARTS; i++) begin
                        if (i == int'(q_slot)) begin
                            sizes_next[i] = sizes_next[i] - 32'd1;
                            sums_next[i]  = sums_next[i] - 32'(cur_reg.item_a);
                        end
                        if (i == int'(cur_reg.part_sel)) begin
                            sizes_next[i] = sizes_next[i] + 32'd1;
                            sums_next[i]  = sums_next[i] + 32'(cur_reg.item_a);
                        end
                    end
                    mem_we       = 1'b1;
                    mem_wa       = item_addr(cur_reg.item_a);
                    mem_wd       = SW'(cur_reg.part_sel);
                    cost_ok_next = 1'b0;
                    state_next   = plst_pkg::S_DONE;
                end else begin
                    s1_next    = q_slot;
                    sum1_next  = sums_rd;
                    mem_ra     = item_addr(cur_reg.item_b);
                    state_next = plst_pkg::S_RDB;
                end
            end
            plst_pkg::S_RDB: begin
                rd_idx  = int'(q_slot);
                s2_next = q_slot;
                if (q_slot == s1_reg) begin
                    state_next = plst_pkg::S_DONE;
                end else begin
                    g_next     = d43 + 43'(sum1_reg) - 43'(sums_rd);
                    mem_we     = 1'b1;
                    mem_wa     = item_addr(cur_reg.item_a);
                    mem_wd     = q_slot;
                    state_next = plst_pkg::S_SWW;
                end
            end
            plst_pkg::S_SWW: begin
                for (int i = 0; i <= MAX_PARTS; i++) begin
                    if (i == int'(s1_reg)) begin
                        sums_next[i] = sums_reg[i] + d32;
                    end
                    if (i == int'(s2_reg)) begin
                        sums_next[i] = sums_reg[i] - d32;
                    end
                end
                mem_we     = 1'b1;
                mem_wa     = item_addr(cur_reg.item_b);
                mem_wd     = s1_reg;
                prod_next  = swp_prod[42:0];
                state_next = plst_pkg::S_SWC;
            end
            plst_pkg::S_SWC: begin
                // Keep a current cost current: add 2*d*(d + S1 - S2)
                if (cost_ok_reg) begin
                    cost_next = cost_reg + {swp_delta[41:0], 1'b0};
                end
                state_next = plst_pkg::S_DONE;
            end
            plst_pkg::S_CDEV: begin
                rd_idx = int'(j_reg);
                if (int'(j_reg) > int'(eff_k)) begin
                    cost_ok_next = 1'b1;
                    state_next   = plst_pkg::S_DONE;
                end else begin
                    dev_next   = (sums_rd >= 32'(target_sum)) ? (sums_rd - 32'(target_sum))
                                                              : (32'(target_sum) - sums_rd);
                    state_next = plst_pkg::S_CSQ;
                end
            end
            plst_pkg::S_CSQ: begin
                sq_next    = sq64[42:0];
                state_next = plst_pkg::S_CACC;
            end
            plst_pkg::S_CACC: begin
                cost_next  = cost_reg + sq_reg;
                j_next     = j_reg + 1'b1;
                state_next = plst_pkg::S_CDEV;
            end
            plst_pkg::S_DONE: begin
                // Load the output register once it is free
                if (!out_valid_reg || out_ready) begin
                    out_next.status       = res_status_reg;
                    out_next.all_assigned = (sizes_reg[0] == 32'd0);
                    out_next.cost_valid   = cost_ok_reg;
                    out_next.cost_value   = cost_ok_reg ? cost_reg : '0;
                    out_next.part_members = res_members_reg;
                    out_next.part_total   = res_total_reg;
                    out_valid_next        = 1'b1;
                    state_next            = plst_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = plst_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= plst_pkg::S_INIT;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            cost_reg      <= '0;
            cost_ok_reg   <= 1'b0;
            for (int i = 0; i <= MAX_PARTS; i++) begin
                sizes_reg[i] <= '0;
                sums_reg[i]  <= '0;
            end
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
            cost_reg      <= cost_next;
            cost_ok_reg   <= cost_ok_next;
            sizes_reg     <= sizes_next;
            sums_reg      <= sums_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cur_reg         <= cur_next;
        s1_reg          <= s1_next;
        s2_reg          <= s2_next;
        sum1_reg        <= sum1_next;
        g_reg           <= g_next;
        prod_reg        <= prod_next;
        dev_reg         <= dev_next;
        sq_reg          <= sq_next;
        j_reg           <= j_next;
        res_status_reg  <= res_status_next;
        res_members_reg <= res_members_next;
        res_total_reg   <= res_total_next;
        out_reg         <= out_next;
    end

endmodule

[rtl/plst_checker.sv]
// ----------------------------------------------------------------------------
// plst_checker
// Port-level checks on the partition table result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    logic [1:0] status;
    logic       all_assigned;
    logic       cost_valid;
    logic [42:0] cost_value;
    logic [10:0] part_members;
    logic [19:0] part_total;

    assign status       = m_tdata[1:0];
    assign all_assigned = m_tdata[2];
    assign cost_valid   = m_tdata[3];
    assign cost_value   = m_tdata[46:4];
    assign part_members = m_tdata[57:47];
    assign part_total   = m_tdata[77:58];

    // A stalled result holds
    `AST_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // A stale cost shows as zero
    `AST_SAME(a_cost_zero, m_tvalid && !cost_valid, cost_value == 43'd0)
    // A failed request reports no part contents
    `AST_SAME(a_fail_empty, m_tvalid && status != plst_pkg::ST_OK,
              part_members == 11'd0 && part_total == 20'd0)
    // Incomplete is only reported while the pool holds numbers
    `AST_SAME(a_incomplete, m_tvalid && status == plst_pkg::ST_INCOMPLETE, !all_assigned)

endmodule

bind partition_local_search_table plst_checker u_plst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
